// File: rtl/core/rtmp_pkg.sv
// Shared types and command codes for the rational-to-residue block.
// Used by the controller, the datapath and the top level.
package rtmp_pkg;

    localparam int WordW = 64;

    // datapath command codes
    typedef logic [3:0] dp_cmd_t;
    localparam dp_cmd_t CMD_NOP      = 4'd0;
    localparam dp_cmd_t CMD_CAPTURE  = 4'd1;
    localparam dp_cmd_t CMD_LOAD_NUM = 4'd2;
    localparam dp_cmd_t CMD_DIV_STEP = 4'd3;
    localparam dp_cmd_t CMD_NUM_FIX  = 4'd4;
    localparam dp_cmd_t CMD_EUC_INIT = 4'd5;
    localparam dp_cmd_t CMD_EUC_STEP = 4'd6;
    localparam dp_cmd_t CMD_MUL_INIT = 4'd7;
    localparam dp_cmd_t CMD_MUL_DBL  = 4'd8;
    localparam dp_cmd_t CMD_MUL_ADD  = 4'd9;
    localparam dp_cmd_t CMD_OUT_ZERO = 4'd10;
    localparam dp_cmd_t CMD_OUT_NRES = 4'd11;
    localparam dp_cmd_t CMD_OUT_ACC  = 4'd12;

    // datapath status toward the controller
    typedef struct packed {
        logic frac;
        logic den_neg;
        logic p_small;
        logic cnt_last;
        logic b_zero;
        logic a_one;
    } dp_status_t;

endpackage

// File: rtl/core/rtmp_datapath.sv
// Datapath: operand capture, bit-serial modulo, shift-subtract extended
// Euclid and shift-add modular multiply. Depends on rtmp_pkg.
module rtmp_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    input  logic [127:0]          in_data,
    input  logic [1:0]            in_user,
    input  rtmp_pkg::dp_cmd_t     cmd,
    output rtmp_pkg::dp_status_t  status,
    output logic [63:0]           residue
);
    import rtmp_pkg::*;

    logic [63:0] prime_reg;
    logic [63:0] num_reg, den_reg;
    logic        frac_reg, uns_reg;
    logic [63:0] rem_reg, sh_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] nres_reg, a_reg, b_reg, t0_reg, t1_reg, bs_reg, ts_reg, acc_reg, res_reg;

    logic [64:0] pw;
    logic        neg_num;
    logic [64:0] div_sh;
    logic [63:0] div_next;
    logic [64:0] bs2, ts2, acc2, accsum;
    logic        grow;
    logic [63:0] ts_dbl, acc_dbl, acc_add, t_sub, t_mod, nfix;

    // hold the modulus; software writes it while idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg <= 64'd2;
        end else if (cfg_wr_en) begin
            prime_reg <= cfg_wr_data;
        end
    end

    assign pw      = {1'b0, prime_reg};
    assign neg_num = ~uns_reg & num_reg[63];

    // one restoring division bit
    assign div_sh   = {rem_reg, sh_reg[63]};
    assign div_next = (div_sh >= pw) ? 64'(div_sh - pw) : div_sh[63:0];

    assign nfix = (neg_num && rem_reg != 64'd0) ? prime_reg - rem_reg : rem_reg;

    // Euclid helpers: shifted divisor and its cofactor doubled mod p
    assign bs2    = {bs_reg, 1'b0};
    assign grow   = bs2 <= {1'b0, a_reg};
    assign ts2    = {ts_reg, 1'b0};
    assign ts_dbl = (ts2 >= pw) ? 64'(ts2 - pw) : ts2[63:0];
    assign t_sub  = t0_reg - ts_reg;
    assign t_mod  = (t0_reg < ts_reg) ? t_sub + prime_reg : t_sub;

    // multiply helpers
    assign acc2    = {acc_reg, 1'b0};
    assign acc_dbl = (acc2 >= pw) ? 64'(acc2 - pw) : acc2[63:0];
    assign accsum  = {1'b0, acc_reg} + {1'b0, nres_reg};
    assign acc_add = (accsum >= pw) ? 64'(accsum - pw) : accsum[63:0];

    // run the commanded operation
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_CAPTURE: begin
                num_reg  <= in_data[63:0];
                den_reg  <= in_data[127:64];
                frac_reg <= in_user[0];
                uns_reg  <= in_user[1];
            end
            CMD_LOAD_NUM: begin
                rem_reg <= 64'd0;
                sh_reg  <= neg_num ? 64'd0 - num_reg : num_reg;
                cnt_reg <= 6'd0;
            end
            CMD_DIV_STEP: begin
                rem_reg <= div_next;
                sh_reg  <= {sh_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            CMD_NUM_FIX: begin
                nres_reg <= nfix;
                rem_reg  <= 64'd0;
                sh_reg   <= den_reg;
                cnt_reg  <= 6'd0;
            end
            CMD_EUC_INIT: begin
                a_reg  <= prime_reg;
                b_reg  <= rem_reg;
                t0_reg <= 64'd0;
                t1_reg <= 64'd1;
                bs_reg <= rem_reg;
                ts_reg <= 64'd1;
            end
            CMD_EUC_STEP: begin
                if (b_reg != 64'd0) begin
                    if (a_reg < b_reg) begin
                        a_reg  <= b_reg;
                        b_reg  <= a_reg;
                        t0_reg <= t1_reg;
                        t1_reg <= t0_reg;
                        bs_reg <= a_reg;
                        ts_reg <= t0_reg;
                    end else if (grow) begin
                        bs_reg <= bs2[63:0];
                        ts_reg <= ts_dbl;
                    end else begin
                        a_reg  <= a_reg - bs_reg;
                        t0_reg <= t_mod;
                        bs_reg <= b_reg;
                        ts_reg <= t1_reg;
                    end
                end
            end
            CMD_MUL_INIT: begin
                acc_reg <= 64'd0;
                sh_reg  <= t0_reg;
                cnt_reg <= 6'd0;
            end
            CMD_MUL_DBL: begin
                acc_reg <= acc_dbl;
            end
            CMD_MUL_ADD: begin
                if (sh_reg[63]) begin
                    acc_reg <= acc_add;
                end
                sh_reg  <= {sh_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            CMD_OUT_ZERO: res_reg <= 64'd0;
            CMD_OUT_NRES: res_reg <= nres_reg;
            CMD_OUT_ACC:  res_reg <= acc_reg;
            default: begin
            end
        endcase
    end

    assign status.frac     = frac_reg;
    assign status.den_neg  = frac_reg & ~uns_reg & den_reg[63];
    assign status.p_small  = prime_reg < 64'd2;
    assign status.cnt_last = cnt_reg == 6'd63;
    assign status.b_zero   = b_reg == 64'd0;
    assign status.a_one    = a_reg == 64'd1;
    assign residue         = res_reg;

endmodule

// File: rtl/core/rtmp_ctrl.sv
// Controller: sequences the datapath per item and owns the result handshake.
// Depends on rtmp_pkg.
module rtmp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [1:0]            m_tuser,
    output rtmp_pkg::dp_cmd_t     cmd,
    input  rtmp_pkg::dp_status_t  status
);
    import rtmp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_NDIV  = 4'd2;
    localparam logic [3:0] ST_NFIX  = 4'd3;
    localparam logic [3:0] ST_DDIV  = 4'd4;
    localparam logic [3:0] ST_EINIT = 4'd5;
    localparam logic [3:0] ST_EUC   = 4'd6;
    localparam logic [3:0] ST_MINIT = 4'd7;
    localparam logic [3:0] ST_MDBL  = 4'd8;
    localparam logic [3:0] ST_MADD  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]    state_reg, state_next;
    dp_cmd_t       sel_reg, sel_next;
    logic [1:0]    flag_reg, flag_next;
    logic          mvalid_reg, mvalid_next;
    logic [1:0]    muser_reg, muser_next;
    logic          out_free;

    assign out_free = ~mvalid_reg | m_tready;
    assign s_tready = state_reg == ST_IDLE;

    // step the sequence
    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        flag_next   = flag_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        muser_next  = muser_reg;
        cmd         = CMD_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.den_neg) begin
                    sel_next   = CMD_OUT_ZERO;
                    flag_next  = 2'b01;
                    state_next = ST_OUT;
                end else if (status.p_small) begin
                    sel_next   = CMD_OUT_ZERO;
                    flag_next  = {status.frac, 1'b0};
                    state_next = ST_OUT;
                end else begin
                    cmd        = CMD_LOAD_NUM;
                    state_next = ST_NDIV;
                end
            end
            ST_NDIV: begin
                cmd = CMD_DIV_STEP;
                if (status.cnt_last) begin
                    state_next = ST_NFIX;
                end
            end
            ST_NFIX: begin
                cmd = CMD_NUM_FIX;
                if (status.frac) begin
                    state_next = ST_DDIV;
                end else begin
                    sel_next   = CMD_OUT_NRES;
                    flag_next  = 2'b00;
                    state_next = ST_OUT;
                end
            end
            ST_DDIV: begin
                cmd = CMD_DIV_STEP;
                if (status.cnt_last) begin
                    state_next = ST_EINIT;
                end
            end
            ST_EINIT: begin
                cmd        = CMD_EUC_INIT;
                state_next = ST_EUC;
            end
            ST_EUC: begin
                if (!status.b_zero) begin
                    cmd = CMD_EUC_STEP;
                end else if (status.a_one) begin
                    state_next = ST_MINIT;
                end else begin
                    sel_next   = CMD_OUT_NRES;
                    flag_next  = 2'b10;
                    state_next = ST_OUT;
                end
            end
            ST_MINIT: begin
                cmd        = CMD_MUL_INIT;
                state_next = ST_MDBL;
            end
            ST_MDBL: begin
                cmd        = CMD_MUL_DBL;
                state_next = ST_MADD;
            end
            ST_MADD: begin
                cmd = CMD_MUL_ADD;
                if (status.cnt_last) begin
                    sel_next   = CMD_OUT_ACC;
                    flag_next  = 2'b00;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MDBL;
                end
            end
            ST_OUT: begin
                // load the output register once the previous beat is gone
                if (out_free) begin
                    cmd         = sel_reg;
                    mvalid_next = 1'b1;
                    muser_next  = flag_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        sel_reg   <= sel_next;
        flag_reg  <= flag_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = muser_reg;

endmodule

// File: rtl/core/rational_to_residue_mod_prime_top.sv
// Top level of the rational-to-residue block: controller plus datapath.
// Depends on rtmp_pkg, rtmp_ctrl and rtmp_datapath.
//
// Usage:
//   Write the modulus p through cfg_wr_en/cfg_wr_data while idle (reset
//   value 2). Send one beat per number on the s_ channel; each gives one
//   result beat on the m_ channel with the residue and two error flags.
//   Integers take a bit-serial reduction of the numerator. A
//   fraction adds a second bit-serial reduction, an extended Euclid pass
//   of shifts, swaps and subtracts, and a shift-add multiply. A negative
//   signed denominator or a modulus below two finishes early, with no
//   reduction. The shared shift/subtract datapath does all of this work;
//   one item is in work at a time.
//   Reset clears the controller and the output valid and sets p to 2.
//   A stalled receiver holds the result beat; the block meanwhile accepts
//   and works on the next item, then waits to deliver it.
module rational_to_residue_mod_prime_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] numerator, [127:64] denominator
    input  logic [1:0]   s_tuser,   // [0] has_denominator, [1] unsigned_mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [63:0] residue
    output logic [1:0]   m_tuser    // [0] negative_denominator, [1] noninvertible
);
    import rtmp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rtmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    rtmp_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .in_user     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .residue     (m_tdata)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for rational_to_residue_mod_prime_top: random and corner
// beats, a built-in residue predictor, and idle phases across several moduli.
// Depends on rtmp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
    import rtmp_pkg::*;

    localparam int  NumPhases  = 8;
    localparam int  RandPerPh  = 81;
    localparam longint Limit   = 20000000;
    localparam int  DrainCyc   = 4000;
    localparam int  MaxReports = 10;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic        frac;
        logic        uns;
    } frac_item_t;

    typedef struct packed {
        logic [63:0] residue;
        logic        neg_den;
        logic        noninv;
    } residue_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [63:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // [63:0] numerator, [127:64] denominator
    logic [1:0]   s_tuser = '0;   // [0] has_denominator, [1] unsigned_mode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // [63:0] residue
    logic [1:0]   m_tuser;        // [0] negative_denominator, [1] noninvertible

    frac_item_t pending_q[$];
    residue_t   residue_q[$];
    logic [63:0] modulus = 64'd2;
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int results_seen = 0;
    int fracs_sent = 0;
    longint cycles = 0;

    rational_to_residue_mod_prime_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // (a * b) mod m over the full 128-bit product
    function automatic logic [63:0] mul_mod128(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    // residue of n/d mod the current modulus, with the two error flags
    function automatic residue_t predict_residue(frac_item_t it, logic [63:0] p);
        residue_t r;
        logic sgn;
        logic [63:0] nres, mag, a, b, q, tmp, t0, t1;
        logic [64:0] sum;
        r = '0;
        sgn = ~it.uns;
        if (it.frac && sgn && it.den[63]) begin
            r.neg_den = 1'b1;
            return r;
        end
        if (p < 64'd2) begin
            r.noninv = it.frac;
            return r;
        end
        if (sgn && it.num[63]) begin
            mag = (64'd0 - it.num) % p;
            nres = (mag != 0) ? p - mag : 64'd0;
        end else begin
            nres = it.num % p;
        end
        if (!it.frac) begin
            r.residue = nres;
            return r;
        end
        // extended Euclid, coefficient of the denominator kept mod p
        a = p;
        b = it.den % p;
        t0 = 64'd0;
        t1 = 64'd1;
        while (b != 0) begin
            q = a / b;
            tmp = a - q * b;
            a = b;
            b = tmp;
            sum = {1'b0, t0} + {1'b0, p} - {1'b0, mul_mod128(q % p, t1, p)};
            tmp = t1;
            t1 = 64'(sum % {1'b0, p});
            t0 = tmp;
        end
        if (a != 64'd1) begin
            r.residue = nres;
            r.noninv = 1'b1;
        end else begin
            r.residue = mul_mod128(nres, t0, p);
        end
        return r;
    endfunction

    // pick a word biased toward the edges and toward multiples of the modulus
    function automatic logic [63:0] pick_word(logic [63:0] p);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = 64'(p) * 64'($urandom_range(0, 3));
            1: w = 64'($urandom_range(0, 20));
            2: w = 64'd0 - 64'($urandom_range(1, 20));
            3: w = p - 64'($urandom_range(0, 2));
            4: w = {1'b0, w[62:0]};
            default: ;
        endcase
        return w;
    endfunction

    task automatic push_item(logic [63:0] n, logic [63:0] d, logic f, logic u);
        frac_item_t it;
        it.num = n;
        it.den = d;
        it.frac = f;
        it.uns = u;
        pending_q.insert(pending_q.size(), it);
    endtask

    // sample between edges so the driver's updates have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || residue_q.size() != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // driver: record accepted beats, then present the next one or idle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                residue_q.insert(residue_q.size(),
                    predict_residue(frac_item_t'({s_tdata[63:0], s_tdata[127:64],
                    s_tuser[0], s_tuser[1]}), modulus));
                if (s_tuser[0]) fracs_sent++;
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    frac_item_t it;
                    it = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {it.den, it.num};
                    s_tuser <= {it.uns, it.frac};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (residue_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("tb: result beat with nothing expected: %h %b", m_tdata, m_tuser);
                end else begin
                    residue_t e;
                    e = residue_q.pop_front();
                    if (m_tdata !== e.residue || m_tuser[0] !== e.neg_den
                            || m_tuser[1] !== e.noninv) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display("tb: mismatch p=%h exp %h neg=%b ninv=%b got %h neg=%b ninv=%b",
                                modulus, e.residue, e.neg_den, e.noninv,
                                m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > Limit) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0] moduli [NumPhases];
        logic [63:0] p;
        moduli[0] = 64'hFFFF_FFFF_FFFF_FFC5;   // largest 64-bit prime
        moduli[1] = 64'd7;
        moduli[2] = 64'd2;
        moduli[3] = 64'd0;
        moduli[4] = 64'd1000003;
        moduli[5] = 64'hFFFF_FFFF_FFFF_FFFF;   // composite, all ones
        moduli[6] = 64'd1;
        moduli[7] = 64'd15;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < NumPhases; ph++) begin
            p = moduli[ph];
            // write the modulus while nothing is in flight
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= p;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            modulus = p;
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 45; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 45; end
                default: begin send_idle = 32; recv_idle = 32; end
            endcase

            // corners: extremes, integers, negative and noninvertible denominators
            push_item(64'd0, 64'd0, 1'b0, 1'b0);
            push_item('1, 64'd5, 1'b0, 1'b1);
            push_item('1, 64'd5, 1'b0, 1'b0);
            push_item(64'h8000_0000_0000_0000, 64'd3, 1'b1, 1'b0);
            push_item(64'd9, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
            push_item(64'd9, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
            push_item(64'd9, '1, 1'b1, 1'b0);
            push_item(64'd9, 64'd0, 1'b1, 1'b1);
            push_item(64'd9, p, 1'b1, 1'b1);
            push_item('1, '1, 1'b1, 1'b1);
            push_item(64'd1, 64'd1, 1'b1, 1'b0);
            push_item(p - 64'd1, p - 64'd1, 1'b1, 1'b1);
            if (ph == 0) begin
                push_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
                push_item(64'd12345, 64'h0000_0001_0000_0001, 1'b1, 1'b1);
                push_item(64'd3, 64'd2, 1'b1, 1'b0);
            end

            // random beats, mostly fractions
            for (int i = 0; i < RandPerPh; i++)
                push_item(pick_word(p), pick_word(p), ($urandom_range(0, 3) != 0),
                    1'($urandom));
            wait_idle();
        end

        repeat (DrainCyc) @(posedge aclk);
        $display("tb: %0d results checked over %0d moduli, %0d fractions, %0d mismatches",
            results_seen, NumPhases, fracs_sent, mismatches);
        if (mismatches == 0 && residue_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
